>>> hdl/stsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsq_pkg: shared types and constants
// Field widths, stream packing widths, operation codes and the command and
// status groups between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package stsq_pkg;

   localparam int TIME_W     = 16;
   localparam int SHIP_W     = 8;
   localparam int KEY_W      = TIME_W + 1;
   localparam int ENTRY_W    = TIME_W + SHIP_W;
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;

   localparam logic [TIME_W-1:0] MIN_WAIT_RESET = 16'd4;

   // operation codes carried on req_tuser
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // sequencer -> datapath
   typedef struct packed {
      logic start;      // capture request, load index
      logic rd_en;      // read table at scan index
      logic idx_dec;
      logic idx_inc;
      logic wr_shift;   // move read entry up one slot
      logic wr_new;     // store new entry at index, bump count
      logic set_found;  // take read entry as query result
      logic set_full;   // flag dropped insert
      logic out_load;   // move result into output register
   } ctl_cmd_type;

   // datapath -> sequencer
   typedef struct packed {
      logic is_query;
      logic full;
      logic idx_zero;
      logic idx_at_count;
      logic ge;         // read time >= search key
      logic out_free;
   } ctl_sts_type;

endpackage

>>> hdl/sorted_timetable_successor_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timetable_successor_query: sorted departure table with search
// Inserts departures in time order and answers next-usable-departure queries.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one request per handshake; req_tuser selects insert (0) or
//   query (1). An insert stores {ship, time} ahead of any equal or later
//   entry; a query with arrival zero returns the earliest entry, otherwise
//   the first entry at or after arrival + min_wait.
//   rsp channel: exactly one response per request, in request order.
//   csr channel: writes min_wait (reset value 4); write only while idle.
// Each scanned slot is a RAM read followed by a compare. An insert scans
//   down from the entry count and moves each equal or later entry up one
//   slot; a query scans up from slot zero until an entry matches or the
//   stored entries run out. A dropped insert scans nothing. The scan length
//   sets the latency. One request is worked at a time; the next is taken
//   the cycle after the result enters the output register.
// Reset: clears the entry count and the response valid, restores min_wait.
// Stall: a held response keeps its register; the next request is still
//   taken and worked, and waits for the register before it finishes.
// ----------------------------------------------------------------------------
module sorted_timetable_successor_query #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // departure_time[15:0], ship_id[23:16], arrival_time[39:24]
   input  logic [stsq_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[0]
   input  logic [stsq_pkg::REQ_USER_W-1:0] req_tuser,
   // response
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // next_departure[15:0], next_ship[23:16]
   output logic [stsq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // found[0], table_full[1]
   output logic [stsq_pkg::RSP_USER_W-1:0] rsp_tuser,
   // min_wait write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [stsq_pkg::TIME_W-1:0]     csr_data
);
   import stsq_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   assign csr_ready = 1'b1;

   stsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   stsq_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> hdl/stsq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsq_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stsq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/stsq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsq_ctrl: request sequencer
// Steps the table scan for insert (downward shift) and query (upward search),
// flags a dropped insert and hands the result to the output register.
// ----------------------------------------------------------------------------
module stsq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  stsq_pkg::ctl_sts_type sts,
   output stsq_pkg::ctl_cmd_type cmd
);
   import stsq_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_INS_RD  = 3'd2;
   localparam logic [2:0] S_INS_CHK = 3'd3;
   localparam logic [2:0] S_QRY_RD  = 3'd4;
   localparam logic [2:0] S_QRY_CHK = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_query) begin
               state_in = S_QRY_RD;
            end else if (sts.full) begin
               cmd.set_full = 1'b1;
               state_in     = S_DONE;
            end else begin
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            if (sts.idx_zero) begin
               cmd.wr_new = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (sts.ge) begin
               cmd.wr_shift = 1'b1;
               cmd.idx_dec  = 1'b1;
               state_in     = S_INS_RD;
            end else begin
               cmd.wr_new = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_QRY_RD: begin
            if (sts.idx_at_count) begin
               state_in = S_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_QRY_CHK;
            end
         end
         S_QRY_CHK: begin
            if (sts.ge) begin
               cmd.set_found = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_QRY_RD;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/stsq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsq_dp: timetable datapath
// Entry RAM, entry count, scan index, search key, min_wait register, result
// and output registers.
// ----------------------------------------------------------------------------
module stsq_dp #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  stsq_pkg::ctl_cmd_type             cmd,
   output stsq_pkg::ctl_sts_type             sts,
   input  logic [stsq_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [stsq_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                              csr_valid,
   input  logic [stsq_pkg::TIME_W-1:0]       csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [stsq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [stsq_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import stsq_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   // request fields
   logic [TIME_W-1:0] req_time;
   logic [SHIP_W-1:0] req_ship;
   logic [TIME_W-1:0] req_arrival;
   assign req_time    = req_tdata[15:0];
   assign req_ship    = req_tdata[23:16];
   assign req_arrival = req_tdata[39:24];

   logic [TIME_W-1:0] min_wait_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     idx_ff;
   logic [KEY_W-1:0]  key_ff;
   logic              is_query_ff;
   logic [ENTRY_W-1:0] new_entry_ff;

   logic              res_found_ff;
   logic              res_full_ff;
   logic [TIME_W-1:0] res_time_ff;
   logic [SHIP_W-1:0] res_ship_ff;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic [CW-1:0]      idx_m1;
   logic [KEY_W-1:0]   key_in;
   logic [IW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_entry;
   logic [ENTRY_W-1:0] wr_entry;
   logic [TIME_W-1:0]  rd_time;
   logic [SHIP_W-1:0]  rd_ship;

   assign idx_m1  = idx_ff - 1'b1;
   assign rd_time = rd_entry[TIME_W-1:0];
   assign rd_ship = rd_entry[ENTRY_W-1:TIME_W];

   // key: insert time; query arrival + min_wait, no wrap, arrival 0 takes head
   always_comb begin
      if (req_tuser[0] == OP_QUERY) begin
         if (req_arrival == '0) begin
            key_in = '0;
         end else begin
            key_in = {1'b0, req_arrival} + {1'b0, min_wait_ff};
         end
      end else begin
         key_in = {1'b0, req_time};
      end
   end

   // insert reads the slot below the index, query reads the index itself
   assign rd_addr  = is_query_ff ? idx_ff[IW-1:0] : idx_m1[IW-1:0];
   assign wr_entry = cmd.wr_shift ? rd_entry : new_entry_ff;

   stsq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.wr_shift | cmd.wr_new),
      .wr_addr (idx_ff[IW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // status to sequencer
   always_comb begin
      sts              = '0;
      sts.is_query     = is_query_ff;
      sts.full         = (count_ff == DEPTH_C);
      sts.idx_zero     = (idx_ff == '0);
      sts.idx_at_count = (idx_ff == count_ff);
      sts.ge           = ({1'b0, rd_time} >= key_ff);
      sts.out_free     = !rsp_valid_ff || rsp_tready;
   end

   // control registers: count and min_wait
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         min_wait_ff <= MIN_WAIT_RESET;
      end else begin
         if (cmd.wr_new) begin
            count_ff <= count_ff + 1'b1;
         end
         if (csr_valid) begin
            min_wait_ff <= csr_data;
         end
      end
   end

   // request capture, scan index and result
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         is_query_ff  <= (req_tuser[0] == OP_QUERY);
         key_ff       <= key_in;
         new_entry_ff <= {req_ship, req_time};
         idx_ff       <= (req_tuser[0] == OP_QUERY) ? '0 : count_ff;
         res_found_ff <= 1'b0;
         res_full_ff  <= 1'b0;
         res_time_ff  <= '0;
         res_ship_ff  <= '0;
      end else begin
         if (cmd.idx_dec) begin
            idx_ff <= idx_m1;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.wr_new) begin
            res_found_ff <= 1'b1;
         end
         if (cmd.set_full) begin
            res_full_ff <= 1'b1;
         end
         if (cmd.set_found) begin
            res_found_ff <= 1'b1;
            res_time_ff  <= rd_time;
            res_ship_ff  <= rd_ship;
         end
      end
   end

   // output register
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {res_ship_ff, res_time_ff};
         rsp_user_ff <= {res_full_ff, res_found_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // entry count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above table depth");

   // a stored entry grows the count by exactly one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_new |=> count_ff == $past(count_ff) + 1'b1)
      else $error("entry count did not advance on insert");

   // insert scan never reads below slot zero
   a_ins_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && !is_query_ff) |-> idx_ff != '0)
      else $error("insert read below table base");

   // a pending result is never overwritten
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending response");
`endif

endmodule

>>> dv/sorted_timetable_successor_query_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timetable_successor_query_tb: self-checking bench for the timetable
// Directed tests walk the empty table, ordered and tied inserts, successor
// queries around the min_wait boundary, min_wait extremes and the full
// table. A long response hold-off then backs the block up into its request
// port. Random phases follow, each under its own min_wait. A local model of
// the sorted table predicts every response; responses are checked in order.
// ----------------------------------------------------------------------------
module sorted_timetable_successor_query_tb;

   import stsq_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int IDLE_TAIL    = 2 * TABLE_DEPTH + 8;
   // ~1570 requests plus sender gaps, receiver stalls, the long hold and idle
   // pauses, all well within this limit
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 255;

   typedef struct packed {
      logic              found;
      logic              table_full;
      logic [TIME_W-1:0] next_departure;
      logic [SHIP_W-1:0] next_ship;
   } departure_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [TIME_W-1:0]     csr_data = '0;

   // local copy of the timetable
   logic [TIME_W-1:0]     tt_times [TABLE_DEPTH];
   logic [SHIP_W-1:0]     tt_ships [TABLE_DEPTH];
   int                    tt_count = 0;
   logic [TIME_W-1:0]     tt_min_wait = MIN_WAIT_RESET;

   departure_result_type  expected_departures [$];
   departure_result_type  rsp_expected;

   int error_count       = 0;
   int responses_checked = 0;
   int inserts_sent      = 0;
   int queries_sent      = 0;
   int settings_written  = 0;
   int cycle_count       = 0;
   int burst_left        = 1;

   // receiver stall control
   logic        long_hold_req = 1'b0;
   int          hold_left     = 0;
   int          pattern_pos   = 0;
   logic [15:0] stall_pattern = '1;

   sorted_timetable_successor_query #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_departures.size());
         $display("tb: failure");
         $finish;
      end
   end

   // predicts one response and updates the local timetable
   function automatic departure_result_type predict_departure(
      input logic              op,
      input logic [TIME_W-1:0] dep,
      input logic [SHIP_W-1:0] ship,
      input logic [TIME_W-1:0] arr
   );
      departure_result_type res;
      logic [TIME_W:0]      earliest_ok;
      int                   slot;
      res = '0;
      if (op == OP_INSERT) begin
         if (tt_count >= TABLE_DEPTH) begin
            res.table_full = 1'b1;
         end else begin
            // first slot holding an equal or later time
            slot = tt_count;
            for (int i = tt_count - 1; i >= 0; i--)
               if (tt_times[i] >= dep) slot = i;
            for (int i = tt_count; i > slot; i--) begin
               tt_times[i] = tt_times[i-1];
               tt_ships[i] = tt_ships[i-1];
            end
            tt_times[slot] = dep;
            tt_ships[slot] = ship;
            tt_count++;
            res.found = 1'b1;
         end
      end else if (tt_count > 0) begin
         if (arr == '0) begin
            res.found          = 1'b1;
            res.next_departure = tt_times[0];
            res.next_ship      = tt_ships[0];
         end else begin
            // sum kept one bit wider, no wrap
            earliest_ok = {1'b0, arr} + {1'b0, tt_min_wait};
            for (int i = tt_count - 1; i >= 0; i--)
               if ({1'b0, tt_times[i]} >= earliest_ok) begin
                  res.found          = 1'b1;
                  res.next_departure = tt_times[i];
                  res.next_ship      = tt_ships[i];
               end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 30)
         $display("mismatch at response %0d: %s got 0x%0h expected 0x%0h",
                  responses_checked, what, got, want);
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_departures.size() == 0) begin
            report_mismatch("unexpected response", 32'({rsp_tuser, rsp_tdata}), '0);
         end else begin
            rsp_expected = expected_departures.pop_front();
            if (rsp_tuser[0] !== rsp_expected.found)
               report_mismatch("found", 32'(rsp_tuser[0]), 32'(rsp_expected.found));
            if (rsp_tuser[1] !== rsp_expected.table_full)
               report_mismatch("table_full", 32'(rsp_tuser[1]),
                               32'(rsp_expected.table_full));
            if (rsp_tdata[15:0] !== rsp_expected.next_departure)
               report_mismatch("next_departure", 32'(rsp_tdata[15:0]),
                               32'(rsp_expected.next_departure));
            if (rsp_tdata[23:16] !== rsp_expected.next_ship)
               report_mismatch("next_ship", 32'(rsp_tdata[23:16]),
                               32'(rsp_expected.next_ship));
            responses_checked++;
         end
      end
   end

   // receiver: long hold on request, else a fresh random 16-bit ready pattern
   always @(posedge clock) begin
      if (long_hold_req) begin
         hold_left     = HOLD_CYCLES;
         long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_pos == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  stall_pattern = '1;
               end
               1: begin
                  stall_pattern = 16'($urandom);
               end
               default: begin
                  stall_pattern = 16'($urandom | $urandom);
               end
            endcase
         end
         rsp_tready <= stall_pattern[pattern_pos];
         pattern_pos = (pattern_pos + 1) % 16;
      end
   end

   // offers one request; bursts with random gaps between them
   task automatic send_request(input logic op, input logic [TIME_W-1:0] dep,
                               input logic [SHIP_W-1:0] ship,
                               input logic [TIME_W-1:0] arr);
      int                   gap;
      departure_result_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {arr, ship, dep};
      do @(posedge clock); while (!req_tready);
      predicted           = predict_departure(op, dep, ship, arr);
      expected_departures = {expected_departures, predicted};
      if (op == OP_INSERT) inserts_sent++;
      else queries_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
   endtask

   // drains every outstanding response, then lets the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_departures.size() != 0);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   task automatic write_min_wait(input logic [TIME_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      tt_min_wait = value;
      settings_written++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // arrival that lands on, or one off, the boundary of a stored departure
   function automatic logic [TIME_W-1:0] boundary_arrival();
      int target;
      target = int'(tt_times[$urandom_range(0, tt_count - 1)]) - int'(tt_min_wait)
               + $urandom_range(0, 2) - 1;
      if (target < 1) target = 1;
      if (target > 65535) target = 65535;
      return target[TIME_W-1:0];
   endfunction

   task automatic test_empty_table();
      send_request(OP_QUERY, 16'hFFFF, 8'hFF, 16'd0);
      send_request(OP_QUERY, 16'h0000, 8'h00, 16'hFFFF);
   endtask

   // ordered inserts with ties on 500 and 65535, newer ones go first
   task automatic test_sorted_insert();
      send_request(OP_INSERT, 16'd500,   8'h01, 16'h0000);
      send_request(OP_INSERT, 16'd500,   8'h02, 16'hFFFF);
      send_request(OP_INSERT, 16'd0,     8'hFF, 16'h0000);
      send_request(OP_INSERT, 16'hFFFF,  8'h80, 16'h1234);
      send_request(OP_INSERT, 16'd100,   8'h7F, 16'h0000);
      send_request(OP_INSERT, 16'hFFFF,  8'h55, 16'h0000);
   endtask

   // min_wait still at its reset value here
   task automatic test_successor_query();
      send_request(OP_QUERY, 16'h0000, 8'h00, 16'd0);
      send_request(OP_QUERY, 16'h0000, 8'h00, 16'd97);
      send_request(OP_QUERY, 16'h0000, 8'h00, 16'd65531);
      send_request(OP_QUERY, 16'h0000, 8'h00, 16'd65532);
   endtask

   task automatic test_min_wait_extremes();
      wait_idle();
      write_min_wait(16'd0);
      send_request(OP_QUERY, 16'h0000, 8'h00, 16'hFFFF);
      send_request(OP_QUERY, 16'h0000, 8'h00, 16'd1);
      wait_idle();
      // sum past 65535 can never match
      write_min_wait(16'hFFFF);
      send_request(OP_QUERY, 16'h0000, 8'h00, 16'd1);
      send_request(OP_QUERY, 16'h0000, 8'h00, 16'd0);
   endtask

   task automatic test_full_table();
      while (tt_count < TABLE_DEPTH)
         send_request(OP_INSERT, 16'($urandom), 8'($urandom), 16'($urandom));
      send_request(OP_INSERT, 16'd1, 8'hAA, 16'h0000);
      send_request(OP_QUERY, 16'h0000, 8'h00, 16'd0);
   endtask

   // receiver holds off while requests keep coming
   task automatic test_input_backpressure();
      wait_idle();
      write_min_wait(MIN_WAIT_RESET);
      long_hold_req = 1'b1;
      repeat (16)
         send_request(OP_QUERY, 16'($urandom), 8'($urandom), boundary_arrival());
   endtask

   task automatic test_random_traffic();
      logic [TIME_W-1:0] phase_wait [6];
      logic              op;
      logic [TIME_W-1:0] dep;
      logic [SHIP_W-1:0] ship;
      logic [TIME_W-1:0] arr;
      int                pick;
      phase_wait[0] = 16'd0;
      phase_wait[1] = 16'hFFFF;
      phase_wait[2] = 16'($urandom_range(1, 255));
      phase_wait[3] = 16'd1;
      phase_wait[4] = 16'($urandom);
      phase_wait[5] = 16'($urandom_range(0, 4095));
      foreach (phase_wait[p]) begin
         wait_idle();
         write_min_wait(phase_wait[p]);
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            dep  = 16'($urandom);
            ship = 8'($urandom);
            arr  = 16'($urandom);
            op   = (pick < 15) ? OP_INSERT : OP_QUERY;
            if (pick >= 15 && pick < 25) arr = '0;
            else if (pick >= 25 && pick < 70) arr = boundary_arrival();
            send_request(op, dep, ship, arr);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_sorted_insert();
      test_successor_query();
      test_min_wait_extremes();
      test_full_table();
      test_input_backpressure();
      test_random_traffic();

      wait_idle();
      $display("run covered %0d inserts and %0d queries over %0d min_wait settings,",
               inserts_sent, queries_sent, settings_written);
      $display("with a full table, tie ordering and a %0d-cycle response hold; %0d checked",
               HOLD_CYCLES, responses_checked);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
